>>> hdl/lagrange_coefficient_mod_prime_macros.svh
// Assertion helpers for the Lagrange coefficient block.
`ifndef LAGRANGE_COEFFICIENT_MOD_PRIME_MACROS_SVH
`define LAGRANGE_COEFFICIENT_MOD_PRIME_MACROS_SVH

// same-cycle implication
`define LCM_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define LCM_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> hdl/lcm_pkg.sv
package lcm_pkg;

	localparam int FIELD_BITS_DEF = 15;
	localparam int MODULUS_RESET  = 3329;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_START,
		ST_RED_T,
		ST_RED_O,
		ST_RED_WAIT,
		ST_INV_INIT,
		ST_INV_STEP,
		ST_INV_SQR,
		ST_INV_WAIT,
		ST_FRAC,
		ST_FRAC_WAIT,
		ST_PROD,
		ST_PROD_WAIT,
		ST_DONE
	} state_t;

	typedef enum logic [1:0] {
		A_ONE,
		A_ACC,
		A_CUR,
		A_FRAC
	} a_sel_t;

	typedef enum logic [2:0] {
		B_TIN,
		B_OIN,
		B_RP,
		B_CUR,
		B_NUM
	} b_sel_t;

	typedef enum logic [2:0] {
		D_T,
		D_O,
		D_ACC,
		D_CUR,
		D_FRAC,
		D_PROD
	} dest_t;

	typedef struct packed {
		logic   load;
		logic   issue;
		a_sel_t a_sel;
		b_sel_t b_sel;
		dest_t  dest;
		logic   inv_init;
		logic   e_shift;
		logic   finish;
		logic   div_run;
	} cmd_t;

	typedef struct packed {
		logic mu_ok;
		logic busy;
		logic skip;
		logic e_bit;
		logic e_zero;
		logic out_free;
	} status_t;

endpackage

>>> hdl/lagrange_coefficient_mod_prime.sv
// channel   | dir | signals                          | payload
// s_axis    | in  | tvalid tready tdata tlast        | target_id, other_id; tlast = last
// m_axis    | out | tvalid tready tdata              | coefficient
// cfg       | in  | valid ready data                 | modulus (always ready)
//
// An id equal to the target only multiplies the running product by one; any other id
// first runs reduction, Fermat inversion and the fraction, all on the shared 3-stage Barrett multiplier.
// After reset and after each modulus write the Barrett reciprocal is recomputed,
// during which no request is taken.
// A request is taken while a finished coefficient still waits on m_axis.
`include "lagrange_coefficient_mod_prime_macros.svh"

module lagrange_coefficient_mod_prime #(
	parameter int FIELD_BITS = lcm_pkg::FIELD_BITS_DEF
) (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  logic                                      cfg_valid,
	output logic                                      cfg_ready,
	input  logic [FIELD_BITS-1:0]                     cfg_data,
	input  logic                                      s_axis_tvalid,
	output logic                                      s_axis_tready,
	// target_id, other_id, zero pad
	input  logic [((2*FIELD_BITS+7)/8)*8-1:0]         s_axis_tdata,
	input  logic                                      s_axis_tlast,
	output logic                                      m_axis_tvalid,
	input  logic                                      m_axis_tready,
	// coefficient, zero pad
	output logic [((FIELD_BITS+7)/8)*8-1:0]           m_axis_tdata
);
	import lcm_pkg::*;

	localparam int OW = ((FIELD_BITS + 7) / 8) * 8;

	cmd_t                  cmd;
	status_t               sts;
	logic [FIELD_BITS-1:0] coeff;

	assign cfg_ready = 1'b1;

	lcm_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(s_axis_tvalid),
		.in_ready(s_axis_tready),
		.sts     (sts),
		.cmd     (cmd)
	);

	lcm_datapath #(.W(FIELD_BITS)) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_data   (cfg_data),
		.target_id  (s_axis_tdata[FIELD_BITS-1:0]),
		.other_id   (s_axis_tdata[2*FIELD_BITS-1:FIELD_BITS]),
		.last       (s_axis_tlast),
		.cmd        (cmd),
		.sts        (sts),
		.out_ready  (m_axis_tready),
		.out_valid  (m_axis_tvalid),
		.coefficient(coeff)
	);

	assign m_axis_tdata = OW'(coeff);

	`LCM_ASSERT_IMP(a_issue_mu, cmd.issue, sts.mu_ok, "multiply issued without reciprocal")
	`LCM_ASSERT_IMP(a_accept_idle, s_axis_tvalid && s_axis_tready, !sts.busy, "accept while busy")
	`LCM_ASSERT_NXT(a_accept_busy, s_axis_tvalid && s_axis_tready, !s_axis_tready, "double accept")
	`LCM_ASSERT_IMP(a_finish_slot, cmd.finish, !m_axis_tvalid || m_axis_tready, "output overwritten")

endmodule

>>> hdl/lcm_modmul.sv
module lcm_modmul #(
	parameter int W = lcm_pkg::FIELD_BITS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           valid,
	input  logic [W-1:0]   a,
	input  logic [W-1:0]   b,
	input  lcm_pkg::dest_t dest,
	input  logic [W-1:0]   m,
	input  logic [2*W-1:0] mu,
	output logic           res_valid,
	output logic [W-1:0]   res,
	output lcm_pkg::dest_t res_dest,
	output logic           busy
);
	import lcm_pkg::*;

	localparam int PW = 2 * W;
	localparam int QW = 4 * W;
	localparam int MW = 3 * W;
	localparam int RW = W + 2;

	logic          v_s1, v_s2, v_s3;
	logic [PW-1:0] p_s1, p_s2;
	logic [PW-1:0] q_s2;
	logic [RW-1:0] r_s3;
	dest_t         d_s1, d_s2, d_s3;
	logic [QW-1:0] pm;
	logic [MW-1:0] qm;
	logic [RW-1:0] m_x, m2_x;

	// Barrett: q = (p * mu) >> 2W, then r = p - q*m stays below 3m
	assign pm   = QW'(p_s1) * QW'(mu);
	assign qm   = MW'(q_s2) * MW'(m);
	assign m_x  = RW'(m);
	assign m2_x = {1'b0, m, 1'b0};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		p_s1 <= PW'(a) * PW'(b);
		d_s1 <= dest;
		p_s2 <= p_s1;
		q_s2 <= pm[QW-1:PW];
		d_s2 <= d_s1;
		r_s3 <= p_s2[RW-1:0] - qm[RW-1:0];
		d_s3 <= d_s2;
	end

	always_comb begin
		if (r_s3 >= m2_x) begin
			res = W'(r_s3 - m2_x);
		end else if (r_s3 >= m_x) begin
			res = W'(r_s3 - m_x);
		end else begin
			res = r_s3[W-1:0];
		end
	end

	assign res_valid = v_s3;
	assign res_dest  = d_s3;
	assign busy      = v_s1 | v_s2 | v_s3;

endmodule

>>> hdl/lcm_datapath.sv
module lcm_datapath #(
	parameter int W = lcm_pkg::FIELD_BITS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_valid,
	input  logic [W-1:0]     cfg_data,
	input  logic [W-1:0]     target_id,
	input  logic [W-1:0]     other_id,
	input  logic             last,
	input  lcm_pkg::cmd_t    cmd,
	output lcm_pkg::status_t sts,
	input  logic             out_ready,
	output logic             out_valid,
	output logic [W-1:0]     coefficient
);
	import lcm_pkg::*;

	localparam int PW = 2 * W;
	localparam int CW = $clog2(2 * W + 1);
	localparam logic [W-1:0] M_RAW = W'(MODULUS_RESET);
	localparam logic [W-1:0] M_RST = (M_RAW < W'(3)) ? W'(3) : M_RAW;

	logic [W-1:0]  m_q;
	logic [PW-1:0] mu_q;
	logic          mu_ok_q;
	logic [W:0]    dr_q;
	logic [CW-1:0] dc_q;
	logic [W:0]    dr_sh, dr_nx;
	logic          dr_ge, dc_last, div_step;

	logic [W-1:0] tin_q, oin_q, t_q, o_q, acc_q, cur_q, frac_q, prod_q, e_q, rp_q, coeff_q;
	logic         last_q, ov_q;
	logic [W-1:0] num, den, op_a, op_b, cfg_eff, mm_res;
	logic         mm_valid, mm_busy;
	dest_t        mm_dest;

	// reciprocal floor(2^(2W) / m), one quotient bit per cycle while the controller is idle
	assign div_step = cmd.div_run && !mu_ok_q;
	assign dr_sh    = {dr_q[W-1:0], (dc_q == '0)};
	assign dr_ge    = dr_sh >= {1'b0, m_q};
	assign dr_nx    = dr_ge ? (dr_sh - {1'b0, m_q}) : dr_sh;
	assign dc_last  = dc_q == CW'(2 * W);
	assign cfg_eff  = (cfg_data < W'(3)) ? W'(3) : cfg_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_q     <= M_RST;
			mu_ok_q <= 1'b0;
			dr_q    <= '0;
			dc_q    <= '0;
			rp_q    <= W'(1);
			ov_q    <= 1'b0;
		end else begin
			if (cfg_valid) begin
				m_q     <= cfg_eff;
				mu_ok_q <= 1'b0;
				dr_q    <= '0;
				dc_q    <= '0;
			end else if (div_step) begin
				dr_q <= dr_nx;
				if (dc_last) begin
					mu_ok_q <= 1'b1;
				end else begin
					dc_q <= dc_q + CW'(1);
				end
			end
			if (ov_q && out_ready && !(cmd.finish && last_q)) begin
				ov_q <= 1'b0;
			end
			if (cmd.finish) begin
				if (last_q) begin
					ov_q <= 1'b1;
					rp_q <= W'(1);
				end else begin
					rp_q <= prod_q;
				end
			end
		end
	end

	assign num = (o_q == '0) ? '0 : (m_q - o_q);
	assign den = (t_q >= o_q) ? (t_q - o_q) : W'({1'b0, t_q} + {1'b0, m_q} - {1'b0, o_q});

	always_comb begin
		case (cmd.a_sel)
			A_ONE:   op_a = W'(1);
			A_ACC:   op_a = acc_q;
			A_CUR:   op_a = cur_q;
			A_FRAC:  op_a = frac_q;
			default: op_a = W'(1);
		endcase
	end

	always_comb begin
		case (cmd.b_sel)
			B_TIN:   op_b = tin_q;
			B_OIN:   op_b = oin_q;
			B_RP:    op_b = rp_q;
			B_CUR:   op_b = cur_q;
			B_NUM:   op_b = num;
			default: op_b = rp_q;
		endcase
	end

	lcm_modmul #(.W(W)) u_modmul (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid    (cmd.issue),
		.a        (op_a),
		.b        (op_b),
		.dest     (cmd.dest),
		.m        (m_q),
		.mu       (mu_q),
		.res_valid(mm_valid),
		.res      (mm_res),
		.res_dest (mm_dest),
		.busy     (mm_busy)
	);

	always_ff @(posedge clk) begin
		if (!cfg_valid && div_step) begin
			mu_q <= {mu_q[PW-2:0], dr_ge};
		end
		if (cmd.load) begin
			tin_q  <= target_id;
			oin_q  <= other_id;
			last_q <= last;
		end
		if (cmd.inv_init) begin
			acc_q <= W'(1);
			cur_q <= den;
			e_q   <= m_q - W'(2);
		end else if (cmd.e_shift) begin
			e_q <= e_q >> 1;
		end
		if (mm_valid) begin
			case (mm_dest)
				D_T:     t_q    <= mm_res;
				D_O:     o_q    <= mm_res;
				D_ACC:   acc_q  <= mm_res;
				D_CUR:   cur_q  <= mm_res;
				D_FRAC:  frac_q <= mm_res;
				D_PROD:  prod_q <= mm_res;
				default: prod_q <= mm_res;
			endcase
		end
		if (cmd.finish && last_q) begin
			coeff_q <= prod_q;
		end
	end

	assign sts.mu_ok    = mu_ok_q;
	assign sts.busy     = mm_busy;
	assign sts.skip     = tin_q == oin_q;
	assign sts.e_bit    = e_q[0];
	assign sts.e_zero   = e_q == '0;
	assign sts.out_free = !ov_q || out_ready;

	assign out_valid   = ov_q;
	assign coefficient = coeff_q;

endmodule

>>> hdl/lcm_ctrl.sv
module lcm_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  lcm_pkg::status_t sts,
	output lcm_pkg::cmd_t    cmd
);
	import lcm_pkg::*;

	state_t state_q, state_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	assign in_ready = (state_q == ST_IDLE) && sts.mu_ok;

	always_comb begin
		state_nx = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_ready && in_valid) state_nx = ST_START;
			end
			ST_START:     state_nx = sts.skip ? ST_PROD : ST_RED_T;
			ST_RED_T:     state_nx = ST_RED_O;
			ST_RED_O:     state_nx = ST_RED_WAIT;
			ST_RED_WAIT: begin
				if (!sts.busy) state_nx = ST_INV_INIT;
			end
			ST_INV_INIT:  state_nx = ST_INV_STEP;
			ST_INV_STEP:  state_nx = sts.e_zero ? ST_FRAC : ST_INV_SQR;
			ST_INV_SQR:   state_nx = ST_INV_WAIT;
			ST_INV_WAIT: begin
				if (!sts.busy) state_nx = ST_INV_STEP;
			end
			ST_FRAC:      state_nx = ST_FRAC_WAIT;
			ST_FRAC_WAIT: begin
				if (!sts.busy) state_nx = ST_PROD;
			end
			ST_PROD:      state_nx = ST_PROD_WAIT;
			ST_PROD_WAIT: begin
				if (!sts.busy) state_nx = ST_DONE;
			end
			ST_DONE: begin
				if (sts.out_free) state_nx = ST_IDLE;
			end
			default:      state_nx = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd          = '0;
		cmd.a_sel    = A_ONE;
		cmd.b_sel    = B_RP;
		cmd.dest     = D_PROD;
		cmd.div_run  = (state_q == ST_IDLE);
		cmd.load     = in_ready && in_valid;
		case (state_q)
			ST_RED_T: begin
				cmd.issue = 1'b1;
				cmd.b_sel = B_TIN;
				cmd.dest  = D_T;
			end
			ST_RED_O: begin
				cmd.issue = 1'b1;
				cmd.b_sel = B_OIN;
				cmd.dest  = D_O;
			end
			ST_INV_INIT: cmd.inv_init = 1'b1;
			ST_INV_STEP: begin
				cmd.issue = !sts.e_zero && sts.e_bit;
				cmd.a_sel = A_ACC;
				cmd.b_sel = B_CUR;
				cmd.dest  = D_ACC;
			end
			ST_INV_SQR: begin
				cmd.issue   = 1'b1;
				cmd.e_shift = 1'b1;
				cmd.a_sel   = A_CUR;
				cmd.b_sel   = B_CUR;
				cmd.dest    = D_CUR;
			end
			ST_FRAC: begin
				cmd.issue = 1'b1;
				cmd.a_sel = A_ACC;
				cmd.b_sel = B_NUM;
				cmd.dest  = D_FRAC;
			end
			ST_PROD: begin
				cmd.issue = 1'b1;
				cmd.a_sel = sts.skip ? A_ONE : A_FRAC;
				cmd.b_sel = B_RP;
				cmd.dest  = D_PROD;
			end
			ST_DONE: cmd.finish = sts.out_free;
			default: ;
		endcase
	end

endmodule

>>> verif/tb_lagrange_coefficient_mod_prime.sv
module tb_lagrange_coefficient_mod_prime;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int FB     = lcm_pkg::FIELD_BITS_DEF;
	localparam int S_W    = ((2*FB+7)/8)*8;
	localparam int M_W    = ((FB+7)/8)*8;
	localparam int SETTLE = 6*FB + 60;

	typedef logic [FB-1:0] field_t;

	class coefficient_scoreboard;
		int unsigned modulus_reg;
		int unsigned partial_product;
		field_t      coef_queue[$];
		int          mismatches;

		function new();
			modulus_reg     = lcm_pkg::MODULUS_RESET;
			partial_product = 1;
			mismatches      = 0;
		endfunction

		function int unsigned field_modulus();
			return (modulus_reg < 3) ? 3 : modulus_reg;
		endfunction

		function int unsigned fermat_inverse(int unsigned x, int unsigned m);
			int unsigned e;
			int unsigned acc;
			int unsigned sq;
			e   = m - 2;
			acc = 1;
			sq  = x % m;
			for (int i = 0; i < FB; i++) begin
				if (e[i])
					acc = (acc * sq) % m;
				sq = (sq * sq) % m;
			end
			return acc;
		endfunction

		function void note_request(field_t tgt, field_t oth, logic lst);
			int unsigned m;
			int unsigned prod;
			int unsigned t;
			int unsigned o;
			int unsigned num;
			int unsigned den;
			int unsigned frac;
			m    = field_modulus();
			prod = partial_product % m;
			if (oth != tgt) begin
				t    = tgt % m;
				o    = oth % m;
				num  = (o == 0) ? 0 : m - o;
				den  = (t >= o) ? t - o : t + m - o;
				frac = (num * fermat_inverse(den, m)) % m;
				prod = (prod * frac) % m;
			end
			if (lst) begin
				coef_queue.push_back(field_t'(prod));
				partial_product = 1;
			end else begin
				partial_product = prod;
			end
		endfunction

		task report(string msg);
			$display("[%0t] mismatch: %s", $realtime, msg);
			mismatches++;
		endtask

		task check_coefficient(logic [M_W-1:0] got);
			field_t want;
			if (coef_queue.size() == 0) begin
				report($sformatf("coefficient %0d with none expected", got));
			end else begin
				want = coef_queue.pop_front();
				if (got !== M_W'(want))
					report($sformatf("coefficient %0d, expected %0d", got, want));
			end
		endtask
	endclass

	logic           clk = 1'b0;
	logic           arst_n;
	logic           cfg_valid;
	logic           cfg_ready;
	logic [FB-1:0]  cfg_data;
	logic           s_axis_tvalid;
	logic           s_axis_tready;
	logic [S_W-1:0] s_axis_tdata;  // target_id, other_id, zero pad
	logic           s_axis_tlast;
	logic           m_axis_tvalid;
	logic           m_axis_tready;
	logic [M_W-1:0] m_axis_tdata;  // coefficient, zero pad
	bit             calm;

	coefficient_scoreboard sb = new();

	lagrange_coefficient_mod_prime #(
		.FIELD_BITS(FB)
	) i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tlast (s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			sb.check_coefficient(m_axis_tdata);
		m_axis_tready <= calm || ($urandom_range(99) >= 23);
	end

	function automatic field_t pick_id(bit wide);
		if (wide)
			return field_t'($urandom_range(2**FB - 1));
		return field_t'($urandom_range(sb.field_modulus() - 1));
	endfunction

	task automatic send_request(field_t tgt, field_t oth, logic lst);
		while (!calm && $urandom_range(99) < 23) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= S_W'({oth, tgt});
		s_axis_tlast  <= lst;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		sb.note_request(tgt, oth, lst);
	endtask

	// id list of one party set, target placed at a random slot or left out
	task automatic send_party_list(output int count);
		int     len;
		int     slot;
		field_t tgt;
		field_t oth;
		len   = $urandom_range(1, 6);
		slot  = $urandom_range(len);
		tgt   = pick_id($urandom_range(9) == 0);
		count = len;
		for (int k = 0; k < len; k++) begin
			oth = (k == slot) ? tgt : pick_id($urandom_range(9) == 0);
			send_request(tgt, oth, k == len - 1);
		end
	endtask

	task automatic drain();
		s_axis_tvalid <= 1'b0;
		while (sb.coef_queue.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_modulus(field_t value);
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		sb.modulus_reg = value;
	endtask

	initial begin
		int unsigned moduli[10];
		int          sent;
		int          n;
		arst_n        = 1'b0;
		cfg_valid     = 1'b0;
		cfg_data      = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tlast  = 1'b0;
		m_axis_tready = 1'b0;
		calm          = 1'b0;
		moduli = '{3, 0, 32749, 32767, 2, 97, 15, 1, 7681, 3329};
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// ordinary list with the target skipped in the middle
		send_request(15'd1, 15'd2, 1'b0);
		send_request(15'd1, 15'd1, 1'b0);
		send_request(15'd1, 15'd3, 1'b1);
		// last item skipped
		send_request(15'd4, 15'd9, 1'b0);
		send_request(15'd4, 15'd4, 1'b1);
		send_request(15'd0, 15'd0, 1'b1);
		// ids at the field extremes and above the modulus
		send_request(15'd0, 15'd32767, 1'b1);
		send_request(15'd32767, 15'd0, 1'b1);
		send_request(15'd32767, 15'd32766, 1'b1);
		send_request(15'd3328, 15'd0, 1'b1);
		send_request(15'd0, 15'd3328, 1'b1);
		// distinct ids, some of them equal modulo the modulus
		send_request(15'd5, 15'd3334, 1'b0);
		send_request(15'd5, 15'd7, 1'b1);
		send_request(15'd3329, 15'd0, 1'b1);
		send_request(15'd21845, 15'd10922, 1'b1);
		send_request(15'd10922, 15'd21845, 1'b1);
		drain();

		for (int ph = 0; ph < 10; ph++) begin
			write_modulus(field_t'(moduli[ph]));
			calm = (ph == 4);
			sent = 0;
			while (sent < 120) begin
				if ($urandom_range(99) < 15) begin
					send_request(field_t'($urandom), field_t'($urandom),
						$urandom_range(2) == 0);
					sent++;
				end else begin
					send_party_list(n);
					sent += n;
				end
			end
			// leave a partial product to carry across the modulus change
			if (ph % 2 == 1)
				send_request(pick_id(1'b0), pick_id(1'b0), 1'b0);
			drain();
		end

		if (sb.mismatches == 0 && sb.coef_queue.size() == 0) begin
			$display("PASS lagrange_coefficient_mod_prime");
		end else begin
			$display("FAIL lagrange_coefficient_mod_prime");
		end
		$finish;
	end

	initial begin
		#12_000_000;
		$display("FAIL lagrange_coefficient_mod_prime");
		$finish;
	end

endmodule
